[hw/rtl/bitmap_slot_allocator_core_macros.svh]
// ---------------------------------------------------------------------------
// Bitmap slot allocator assertion macros
// Immediate-cycle and next-cycle property checks used by the core.
// ---------------------------------------------------------------------------
`ifndef BITMAP_SLOT_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_SLOT_ALLOCATOR_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// check cons in the same cycle as ante
`define BSA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bsa: same-cycle check failed");
// check cons in the cycle after ante
`define BSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bsa: next-cycle check failed");
`else
`define BSA_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define BSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/bsa_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bitmap slot allocator package
// Sizes, codes, summary interface types and bit search functions.
// ---------------------------------------------------------------------------
package bsa_pkg;

    localparam int MAP_WORDS = 16;
    localparam int WORD_AW   = 4;
    localparam int SLOT_W    = 10;
    localparam int CNT_W     = 11;
    localparam int DATA_W    = 64;
    localparam logic [CNT_W-1:0] SLOT_CAP = 11'd1024;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_FREE = 2'd2
    } t_status;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // per-word summary update, written with the bitmap word
    typedef struct packed {
        logic               we;
        logic [WORD_AW-1:0] word;
        logic               has_free;
        logic               has_used;
    } t_sum_upd;

    // summary search results around the queried word
    typedef struct packed {
        logic               free_found;
        logic [WORD_AW-1:0] free_word;
        logic               used_found;
        logic [WORD_AW-1:0] used_word;
    } t_sum_res;

    function automatic logic [2:0] lsb8(logic [7:0] v);
        logic [2:0] n;
        n = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (v[i]) n = 3'(i);
        end
        return n;
    endfunction

    function automatic logic [2:0] msb8(logic [7:0] v);
        logic [2:0] n;
        n = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (v[i]) n = 3'(i);
        end
        return n;
    endfunction

    function automatic logic [5:0] lsb64(logic [63:0] v);
        logic [7:0] nz;
        logic [2:0] b;
        for (int i = 0; i < 8; i++) nz[i] = |v[i*8 +: 8];
        b = lsb8(nz);
        return {b, lsb8(v[{b, 3'b000} +: 8])};
    endfunction

    function automatic logic [5:0] msb64(logic [63:0] v);
        logic [7:0] nz;
        logic [2:0] b;
        for (int i = 0; i < 8; i++) nz[i] = |v[i*8 +: 8];
        b = msb8(nz);
        return {b, msb8(v[{b, 3'b000} +: 8])};
    endfunction

    function automatic logic [3:0] lsb16(logic [15:0] v);
        logic h;
        h = ~(|v[7:0]);
        return {h, lsb8(h ? v[15:8] : v[7:0])};
    endfunction

    function automatic logic [3:0] msb16(logic [15:0] v);
        logic h;
        h = |v[15:8];
        return {h, msb8(h ? v[15:8] : v[7:0])};
    endfunction

endpackage

[hw/rtl/bsa_word_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bitmap word memory
// One write and one registered read port; unwritten words read as all free.
// ---------------------------------------------------------------------------
module bsa_word_ram
    import bsa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_we,
    input  logic [WORD_AW-1:0] i_waddr,
    input  logic [DATA_W-1:0]  i_wdata,
    input  logic               i_re,
    input  logic [WORD_AW-1:0] i_raddr,
    output logic [DATA_W-1:0]  o_rdata
);

    logic [DATA_W-1:0]    r_mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] r_vld;
    logic [DATA_W-1:0]    r_rdata;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        if (i_re) r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) r_vld[i_waddr] <= 1'b1;
            if (i_re) r_rd_vld <= r_vld[i_raddr];
        end
    end

    // a word never written holds its reset value: every slot free
    assign o_rdata = r_rd_vld ? r_rdata : '1;

endmodule

[hw/rtl/bsa_summary.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bitmap word summary
// Per-word free/used flags and searches above and below a given word.
// ---------------------------------------------------------------------------
module bsa_summary
    import bsa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_sum_upd           i_upd,
    input  logic [WORD_AW-1:0] i_word,
    output t_sum_res           o_res
);

    logic [MAP_WORDS-1:0] r_has_free;
    logic [MAP_WORDS-1:0] r_has_used;
    logic [MAP_WORDS-1:0] w_free_above;
    logic [MAP_WORDS-1:0] w_used_below;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_free <= '1;
            r_has_used <= '0;
        end else if (i_upd.we) begin
            r_has_free[i_upd.word] <= i_upd.has_free;
            r_has_used[i_upd.word] <= i_upd.has_used;
        end
    end

    // only words strictly above / below the queried one
    always_comb begin
        for (int i = 0; i < MAP_WORDS; i++) begin
            w_free_above[i] = r_has_free[i] && (WORD_AW'(i) > i_word);
            w_used_below[i] = r_has_used[i] && (WORD_AW'(i) < i_word);
        end
    end

    assign o_res.free_found = |w_free_above;
    assign o_res.free_word  = lsb16(w_free_above);
    assign o_res.used_found = |w_used_below;
    assign o_res.used_word  = msb16(w_used_below);

endmodule

[hw/rtl/bitmap_slot_allocator_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bitmap slot allocator core
// First-free allocator of 1024 slots over sixteen 64-bit bitmap words.
// ---------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel: tuser[0] selects allocate (0) or
//   free (1), tdata[9:0] names the slot to free. Each request gives exactly
//   one result word on m_axis: granted or freed slot, status, lowest free
//   slot and high-water mark after the request.
//   One request is in work at a time. Allocate while full goes straight
//   from S_IDLE to S_DONE; other requests read their word in S_RD, and add
//   S_RD2 when the next free word (allocate) or the last used word (free of
//   the top slot) lies in another bitmap word and a second read of the word
//   memory is needed. The input reopens as the result is loaded into the
//   output register.
//   The memory has a single read port: one read per cycle.
//   A per-word summary of free and used flags picks that second word at once.
//   Reset gives an all-free map at once (word valid bits, no clearing pass),
//   lowest free slot 0 and high-water mark 0.
//   The result sits in an output register; while the receiver stalls, the
//   block still accepts and works on the next request and holds its result
//   until the register drains.
// ---------------------------------------------------------------------------
`include "bitmap_slot_allocator_core_macros.svh"

module bitmap_slot_allocator_core
    import bsa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [9:0] slot_to_free, [15:10] zero
    input  logic [0:0]  s_axis_tuser,  // [0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // [9:0] slot_index, [11:10] status,
                                       // [22:12] lowest_free, [33:23] high_water
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_RD2,
        S_DONE
    } t_state;

    t_state             r_state, n_state;
    logic               r_op, n_op;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    t_status            r_status, n_status;
    logic [WORD_AW-1:0] r_w2, n_w2;
    logic [CNT_W-1:0]   r_lowest, n_lowest;
    logic [CNT_W-1:0]   r_hw, n_hw;
    logic               r_out_valid, n_out_valid;
    logic [39:0]        r_out_data, n_out_data;

    logic               ram_we, ram_re;
    logic [WORD_AW-1:0] ram_raddr;
    logic [DATA_W-1:0]  ram_rdata;
    logic [DATA_W-1:0]  w_mask, w_new;
    logic [WORD_AW-1:0] w_word;
    logic [CNT_W-1:0]   w_slot_p1;
    t_sum_upd           sum_upd;
    t_sum_res           sum_res;

    bsa_word_ram u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (ram_we),
        .i_waddr (w_word),
        .i_wdata (w_new),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bsa_summary u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (sum_upd),
        .i_word  (w_word),
        .o_res   (sum_res)
    );

    assign w_word    = r_slot[SLOT_W-1:6];
    assign w_mask    = DATA_W'(1) << r_slot[5:0];
    assign w_new     = (r_op == OP_ALLOC) ? (ram_rdata & ~w_mask) : (ram_rdata | w_mask);
    assign w_slot_p1 = {1'b0, r_slot} + CNT_W'(1);

    // summary follows every bitmap write
    assign sum_upd.we       = ram_we;
    assign sum_upd.word     = w_word;
    assign sum_upd.has_free = |w_new;
    assign sum_upd.has_used = ~(&w_new);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_slot      = r_slot;
        n_status    = r_status;
        n_w2        = r_w2;
        n_lowest    = r_lowest;
        n_hw        = r_hw;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = w_word;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op     = s_axis_tuser[0];
                    n_status = ST_OK;
                    if (s_axis_tuser[0] == OP_ALLOC) begin
                        if (r_lowest[CNT_W-1]) begin
                            // map full: report and leave state alone
                            n_status = ST_FULL;
                            n_slot   = '0;
                            n_state  = S_DONE;
                        end else begin
                            n_slot    = r_lowest[SLOT_W-1:0];
                            ram_re    = 1'b1;
                            ram_raddr = r_lowest[SLOT_W-1:6];
                            n_state   = S_RD;
                        end
                    end else begin
                        n_slot    = s_axis_tdata[SLOT_W-1:0];
                        ram_re    = 1'b1;
                        ram_raddr = s_axis_tdata[SLOT_W-1:6];
                        n_state   = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_DONE;
                if (r_op == OP_ALLOC) begin
                    ram_we = 1'b1;
                    if (w_slot_p1 > r_hw) n_hw = w_slot_p1;
                    if (|w_new) begin
                        n_lowest = {1'b0, w_word, lsb64(w_new)};
                    end else if (sum_res.free_found) begin
                        // next free slot lives in a higher word: fetch it
                        ram_re    = 1'b1;
                        ram_raddr = sum_res.free_word;
                        n_w2      = sum_res.free_word;
                        n_state   = S_RD2;
                    end else begin
                        n_lowest = SLOT_CAP;
                    end
                end else if (ram_rdata[r_slot[5:0]]) begin
                    // slot already free: drop the request
                    n_status = ST_BAD_FREE;
                    n_slot   = '0;
                end else begin
                    ram_we = 1'b1;
                    if ({1'b0, r_slot} < r_lowest) n_lowest = {1'b0, r_slot};
                    if (w_slot_p1 >= r_hw) begin
                        if (~(&w_new)) begin
                            n_hw = {1'b0, w_word, msb64(~w_new)} + CNT_W'(1);
                        end else if (sum_res.used_found) begin
                            // top used slot lives in a lower word: fetch it
                            ram_re    = 1'b1;
                            ram_raddr = sum_res.used_word;
                            n_w2      = sum_res.used_word;
                            n_state   = S_RD2;
                        end else begin
                            n_hw = '0;
                        end
                    end
                end
            end
            S_RD2: begin
                n_state = S_DONE;
                if (r_op == OP_ALLOC) begin
                    n_lowest = {1'b0, r_w2, lsb64(ram_rdata)};
                end else begin
                    n_hw = {1'b0, r_w2, msb64(~ram_rdata)} + CNT_W'(1);
                end
            end
            S_DONE: begin
                // hold the result until the output register has room
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {6'b0, r_hw, r_lowest, r_status, r_slot};
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_lowest    <= '0;
            r_hw        <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_lowest    <= n_lowest;
            r_hw        <= n_hw;
            r_op        <= n_op;
            r_slot      <= n_slot;
            r_status    <= n_status;
            r_w2        <= n_w2;
            r_out_data  <= n_out_data;
        end
    end

    // every slot below the lowest free one is in use, so it cannot pass the mark
    `BSA_ASSERT_NOW(a_lowest_le_hw, i_clk, i_rst_n, 1'b1, r_lowest <= r_hw)
    // a full map is reported exactly as the capacity
    `BSA_ASSERT_NOW(a_full_exact, i_clk, i_rst_n, r_lowest[CNT_W-1], r_lowest == SLOT_CAP)
    // an error result never names a slot
    `BSA_ASSERT_NOW(a_err_slot_zero, i_clk, i_rst_n,
        m_axis_tvalid && (m_axis_tdata[11:10] != ST_OK), m_axis_tdata[9:0] == '0)
    // an accepted request leaves the idle state
    `BSA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready, r_state != S_IDLE)

endmodule
